// ===== src/dcrf_pkg.sv =====
`default_nettype none

package dcrf_pkg;

   localparam int DRIVES_DEFAULT = 4;

   // register offsets
   localparam logic [3:0] OFF_SECT_HI  = 4'd1;
   localparam logic [3:0] OFF_SECT_MID = 4'd2;
   localparam logic [3:0] OFF_SECT_LO  = 4'd3;
   localparam logic [3:0] OFF_DMA_HI   = 4'd4;
   localparam logic [3:0] OFF_DMA_MID  = 4'd5;
   localparam logic [3:0] OFF_DMA_LO   = 4'd6;
   localparam logic [3:0] OFF_COUNT    = 4'd7;
   localparam logic [3:0] OFF_STATUS   = 4'd8;

   // command bytes
   localparam logic [7:0] CMD_SELECT_MAX = 8'h0F;
   localparam logic [7:0] CMD_SIZE_128   = 8'h10;
   localparam logic [7:0] CMD_SIZE_256   = 8'h11;
   localparam logic [7:0] CMD_SIZE_512   = 8'h12;
   localparam logic [7:0] CMD_SIZE_1024  = 8'h13;
   localparam logic [7:0] CMD_READ       = 8'h20;
   localparam logic [7:0] CMD_WRITE      = 8'h21;
   localparam logic [7:0] CMD_MOUNT      = 8'h22;
   localparam logic [7:0] CMD_UNMOUNT    = 8'h23;
   localparam logic [7:0] CMD_SEEK_LAST  = 8'h24;
   localparam logic [7:0] CMD_SEEK_END   = 8'h25;
   localparam logic [7:0] CMD_ERR_SYNC   = 8'h80;

   localparam logic [7:0] STATUS_NO_DRIVE = 8'h80;

   typedef struct packed {
      logic        action;
      logic [3:0]  offset;
      logic [7:0]  write_data;
      logic        mount_ok;
      logic [31:0] medium_size;
      logic        medium_fault;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        dma_start;
      logic [23:0] dma_start_address;
      logic [17:0] dma_bytes;
      logic        dma_to_disk;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] sector_pointer;
      logic [23:0] dma_pointer;
      logic [7:0]  sector_total;
      logic [1:0]  size_code;
      logic [31:0] medium_bytes;
      logic        mounted_flag;
      logic        writable_flag;
      logic        error_flag;
   } drive_entry_type;

   localparam drive_entry_type DRIVE_RESET = '{
      sector_pointer: 32'd0,
      dma_pointer:    24'd0,
      sector_total:   8'd1,
      size_code:      2'd2,
      medium_bytes:   32'd0,
      mounted_flag:   1'b0,
      writable_flag:  1'b0,
      error_flag:     1'b1
   };

endpackage

`default_nettype wire

// ===== src/disk_controller_register_file.sv =====
// Byte-wide register window for up to NUM_DRIVES disk drives. Offsets 1-3 hold the
// selected drive's sector pointer bits 23:0 (high to low byte), 4-6 its 24-bit
// DMA pointer, 7 its sector count, and 8 reads status / takes commands on writes.
// Every access returns exactly one rsp item: read_data for reads (0 for writes) and,
// for a transfer command that passes its mounted / writable / bounds / fault
// checks, a DMA request (dma_start with start address, byte count, direction).
// The block takes one item per cycle while the output is not stalled; an
// accepted item passes through stage 1 and then the output register. The
// per-drive state memory has a registered read: an item reads its drive's
// entry at acceptance, a write item writes it back as it leaves stage 1, and an
// item that follows on the same drive takes the written-back entry by forwarding,
// so back-to-back accesses to one drive never stall. Per-drive entries start at
// their reset value through a valid bit per drive; no clearing pass is needed.
// The csr port holds mount_writable (reset 1) and is always ready.
`default_nettype none

module disk_controller_register_file
   import dcrf_pkg::*;
#(
   parameter int NUM_DRIVES = DRIVES_DEFAULT
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_ready,
   input  wire req_item_type req_item,
   output logic          rsp_valid,
   input  wire           rsp_ready,
   output rsp_item_type  rsp_item,
   input  wire           csr_valid,
   output logic          csr_ready,
   input  wire           csr_data
);

   localparam int         DRV_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
   localparam logic [4:0] NDRV  = 5'(NUM_DRIVES);

   // configuration
   logic mount_writable_ff;

   // selected drive, updated as soon as a select command is accepted
   logic [3:0] sel_drive_ff, sel_drive_in;

   // per-drive state memory and its valid bits
   drive_entry_type            mem [NUM_DRIVES];
   logic [NUM_DRIVES-1:0]      vld_ff;

   // stage 1: item whose entry has been read
   logic            s1_vld_ff;
   req_item_type    s1_item_ff;
   logic [3:0]      s1_drv_ff;
   drive_entry_type rd_ff;
   logic            rd_vld_ff, rd_vld_in;
   logic            fwd_ff;
   drive_entry_type fwd_ent_ff;

   // output register
   logic         rsp_vld_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic            accept;
   logic            out_free;
   logic            s1_adv;
   logic            s1_exists;
   logic            wr_en;
   logic            fwd;
   logic [DRV_W-1:0] rd_addr;
   logic [DRV_W-1:0] wr_addr;
   drive_entry_type cur;
   drive_entry_type nxt;

   // transfer arithmetic
   logic [17:0] xfer_bytes;
   logic [41:0] xfer_start;
   logic        xfer_beyond;
   logic        xfer_fail;
   logic        to_disk;
   logic [31:0] last_sect;
   logic [7:0]  cmd;
   logic [7:0]  status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mount_writable_ff <= 1'b1;
      end else if (csr_valid) begin
         mount_writable_ff <= csr_data;
      end
   end

   // handshake: stage 1 drains into the output register when it has room
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign s1_adv    = s1_vld_ff && out_free;
   assign req_ready = !s1_vld_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_item_ff;

   // drive select takes effect at acceptance so the next item reads the new drive
   always_comb begin
      sel_drive_in = sel_drive_ff;
      if (accept && req_item.action && req_item.offset == OFF_STATUS &&
          req_item.write_data <= CMD_SELECT_MAX) begin
         sel_drive_in = req_item.write_data[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_drive_ff <= 4'd0;
      end else begin
         sel_drive_ff <= sel_drive_in;
      end
   end

   assign rd_addr   = sel_drive_ff[DRV_W-1:0];
   assign wr_addr   = s1_drv_ff[DRV_W-1:0];
   assign s1_exists = {1'b0, s1_drv_ff} < NDRV;
   assign wr_en     = s1_adv && s1_exists && s1_item_ff.action;
   // forward the entry being written back when the next item hits the same drive
   assign fwd       = wr_en && (s1_drv_ff == sel_drive_ff);
   assign rd_vld_in = ({1'b0, sel_drive_ff} < NDRV) ? vld_ff[rd_addr] : 1'b0;

   // registered read; hold the forwarded entry beside it
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff      <= mem[rd_addr];
         rd_vld_ff  <= rd_vld_in;
         fwd_ff     <= fwd;
         fwd_ent_ff <= nxt;
         s1_item_ff <= req_item;
         s1_drv_ff  <= sel_drive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   // write back the modified entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // an entry never written reads as the reset entry
   assign cur = fwd_ff ? fwd_ent_ff : (rd_vld_ff ? rd_ff : DRIVE_RESET);
   assign cmd = s1_item_ff.write_data;

   // sizes in bytes: shift by size_code + 7
   assign xfer_bytes  = (18'(cur.sector_total) << 7) << cur.size_code;
   assign xfer_start  = (42'(cur.sector_pointer) << 7) << cur.size_code;
   assign xfer_beyond = ({1'b0, xfer_start} + 43'(xfer_bytes)) > 43'(cur.medium_bytes);
   assign to_disk     = (cmd == CMD_WRITE);
   assign xfer_fail   = !cur.mounted_flag || (to_disk && !cur.writable_flag) ||
                        xfer_beyond || s1_item_ff.medium_fault;
   assign last_sect   = (cur.medium_bytes >> 7) >> cur.size_code;
   assign status      = {cur.error_flag, cur.writable_flag, cur.size_code, s1_drv_ff};

   // modify: new entry and result of the item in stage 1
   always_comb begin
      nxt         = cur;
      rsp_item_in = '0;
      if (!s1_item_ff.action) begin
         if (s1_item_ff.offset == OFF_STATUS) begin
            rsp_item_in.read_data = s1_exists ? status : STATUS_NO_DRIVE;
         end else if (s1_exists) begin
            case (s1_item_ff.offset)
               OFF_SECT_HI:  rsp_item_in.read_data = cur.sector_pointer[23:16];
               OFF_SECT_MID: rsp_item_in.read_data = cur.sector_pointer[15:8];
               OFF_SECT_LO:  rsp_item_in.read_data = cur.sector_pointer[7:0];
               OFF_DMA_HI:   rsp_item_in.read_data = cur.dma_pointer[23:16];
               OFF_DMA_MID:  rsp_item_in.read_data = cur.dma_pointer[15:8];
               OFF_DMA_LO:   rsp_item_in.read_data = cur.dma_pointer[7:0];
               OFF_COUNT:    rsp_item_in.read_data = cur.sector_total;
               default:      rsp_item_in.read_data = 8'd0;
            endcase
         end
      end else begin
         unique case (s1_item_ff.offset)
            OFF_SECT_HI:  nxt.sector_pointer[23:16] = cmd;
            OFF_SECT_MID: nxt.sector_pointer[15:8]  = cmd;
            OFF_SECT_LO:  nxt.sector_pointer[7:0]   = cmd;
            OFF_DMA_HI:   nxt.dma_pointer[23:16]    = cmd;
            OFF_DMA_MID:  nxt.dma_pointer[15:8]     = cmd;
            OFF_DMA_LO:   nxt.dma_pointer[7:0]      = cmd;
            OFF_COUNT:    nxt.sector_total          = cmd;
            OFF_STATUS: begin
               unique case (cmd) inside
                  [CMD_SIZE_128:CMD_SIZE_1024]: begin
                     nxt.size_code = cmd[1:0];
                  end
                  CMD_READ, CMD_WRITE: begin
                     if (xfer_fail) begin
                        nxt.error_flag = 1'b1;
                     end else begin
                        rsp_item_in.dma_start         = s1_exists;
                        rsp_item_in.dma_start_address = cur.dma_pointer;
                        rsp_item_in.dma_bytes         = xfer_bytes;
                        rsp_item_in.dma_to_disk       = to_disk && s1_exists;
                        nxt.dma_pointer    = cur.dma_pointer + 24'(xfer_bytes);
                        nxt.sector_pointer = cur.sector_pointer + 32'(cur.sector_total);
                     end
                  end
                  CMD_MOUNT: begin
                     // drop, then remount from the sampled medium
                     nxt.sector_pointer = 32'd0;
                     if (s1_item_ff.mount_ok && s1_item_ff.medium_size != 32'd0) begin
                        nxt.error_flag    = 1'b0;
                        nxt.mounted_flag  = 1'b1;
                        nxt.writable_flag = mount_writable_ff;
                        nxt.medium_bytes  = s1_item_ff.medium_size;
                     end else begin
                        nxt.error_flag    = 1'b1;
                        nxt.mounted_flag  = 1'b0;
                        nxt.writable_flag = 1'b0;
                        nxt.medium_bytes  = 32'd0;
                     end
                  end
                  CMD_UNMOUNT: begin
                     if (cur.mounted_flag) begin
                        nxt.mounted_flag  = 1'b0;
                        nxt.writable_flag = 1'b0;
                        nxt.error_flag    = 1'b1;
                        nxt.medium_bytes  = 32'd0;
                     end
                  end
                  CMD_SEEK_LAST: nxt.sector_pointer = last_sect - 32'd1;
                  CMD_SEEK_END:  nxt.sector_pointer = last_sect;
                  CMD_ERR_SYNC:  nxt.error_flag     = !cur.mounted_flag;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      // a missing drive yields no DMA request
      if (!s1_exists) begin
         rsp_item_in.dma_start_address = 24'd0;
         rsp_item_in.dma_bytes         = 18'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire
